// ===== hdl/epsm_pkg.sv =====
package epsm_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDXW = 2;

  // Defaults for top-level parameters
  localparam int unsigned CHANNELS_DEF   = 2;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [TIME_W-1:0]  NOISE_RST = 16'd1000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd321699;
  localparam logic [SPEED_W-1:0] LIMIT_RST = 16'd51200;
  localparam logic [TIME_W-1:0]  STALL_RST = 16'd500;

  // Register indexes
  typedef enum logic [CFG_IDXW-1:0] {
    CFG_NOISE = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_STALL = 2'd3
  } cfg_idx_e;

  // Event kinds after decode
  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_TICK    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } st_e;

  typedef struct packed {
    logic [TIME_W-1:0]  noise_period;
    logic [SCALE_W-1:0] speed_scale;
    logic [SPEED_W-1:0] speed_limit;
    logic [TIME_W-1:0]  stall_ticks;
  } cfg_t;

  typedef struct packed {
    op_e               kind;
    logic              ch_ok;
    logic              channel;
    logic [TIME_W-1:0] capture_time;
  } cmd_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] pulse_count;
    logic [SPEED_W-1:0]        speed;
    logic                      signal_ok;
    logic                      pulse_accepted;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [SCALE_W-1:0] dividend;
    logic [TIME_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SCALE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/epsm_fifo.sv =====
module epsm_fifo import epsm_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/epsm_front.sv =====
module epsm_front import epsm_pkg::*; #(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        op_i,
  input  logic              channel_i,
  input  logic [TIME_W-1:0] capture_time_i,
  input  logic              cmd_pop_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o
);

  cmd_t                   cmd_in;
  logic                   ch_ok;
  logic                   cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  // channel 1 exists only with more than one channel
  assign ch_ok = (CHANNELS > 1) || (channel_i == 1'b0);

  // decode: capture or clear on a missing channel, and op 3, become a no-op
  always_comb begin
    cmd_in.ch_ok        = ch_ok;
    cmd_in.channel      = channel_i;
    cmd_in.capture_time = capture_time_i;
    case (op_i)
      2'd0:    cmd_in.kind = ch_ok ? OP_CAPTURE : OP_NONE;
      2'd1:    cmd_in.kind = OP_TICK;
      2'd2:    cmd_in.kind = ch_ok ? OP_CLEAR : OP_NONE;
      default: cmd_in.kind = OP_NONE;
    endcase
  end

  epsm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;
  assign cmd_o       = cmd_t'(cmd_raw);

endmodule

// ===== hdl/epsm_div.sv =====
module epsm_div import epsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNTW = $clog2(SCALE_W);

  logic [TIME_W-1:0]  rem_q;
  logic [SCALE_W-1:0] quo_q;
  logic [TIME_W-1:0]  dsr_q;
  logic [CNTW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [TIME_W:0]    trial;
  logic [TIME_W+1:0]  diff;

  // one restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_q, quo_q[SCALE_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= CNTW'(cnt_q + 1'b1);
        if (cnt_q == CNTW'(SCALE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[TIME_W+1]) begin
        rem_q <= diff[TIME_W-1:0];
      end else begin
        rem_q <= trial[TIME_W-1:0];
      end
      quo_q <= {quo_q[SCALE_W-2:0], !diff[TIME_W+1]};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/epsm_back.sv =====
module epsm_back import epsm_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output logic     res_push_o,
  output res_t     res_o,
  input  logic     res_full_i
);

  localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  st_e  st_q, st_d;
  cmd_t cur_q;
  logic acc_q;
  logic [CHW-1:0] tick_idx_q;

  // per-channel state
  logic [COUNT_W-1:0] total_q [CHANNELS];
  logic [TIME_W-1:0]  last_q  [CHANNELS];
  logic [SPEED_W-1:0] speed_q [CHANNELS];
  logic               flag_q  [CHANNELS];
  logic [TIME_W-1:0]  idle_q  [CHANNELS];
  logic [COUNT_W-1:0] seen_q  [CHANNELS];

  logic [CHW-1:0]     addr;
  logic [COUNT_W-1:0] tot_rd;
  logic [TIME_W-1:0]  period, idle_inc;
  logic               noise_hit, period_zero, tick_last, is_idle;

  // single shared access point: tick walk or the event's channel
  assign addr        = (st_q == ST_EXEC && cur_q.kind == OP_TICK) ? tick_idx_q
                                                                 : CHW'(cur_q.channel);
  assign tot_rd      = total_q[addr];
  assign period      = cur_q.capture_time - last_q[addr];
  assign noise_hit   = period < cfg_i.noise_period;
  assign period_zero = (period == '0);
  assign is_idle     = (tot_rd == seen_q[addr]);
  assign idle_inc    = TIME_W'(idle_q[addr] + 1'b1);
  assign tick_last   = (tick_idx_q == CHW'(CHANNELS - 1));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) st_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (cur_q.kind)
          OP_CAPTURE: st_d = (!noise_hit && !period_zero) ? ST_DIV : ST_OUT;
          OP_TICK:    st_d = tick_last ? ST_OUT : ST_EXEC;
          default:    st_d = ST_OUT;
        endcase
      end
      ST_DIV: begin
        if (div_rsp_i.done) st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!res_full_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o          = (st_q == ST_IDLE) && cmd_valid_i;
    div_req_o.start    = (st_q == ST_EXEC) && (cur_q.kind == OP_CAPTURE)
                         && !noise_hit && !period_zero;
    div_req_o.dividend = cfg_i.speed_scale;
    div_req_o.divisor  = period;
    res_push_o         = (st_q == ST_OUT) && !res_full_i;
    if (cur_q.ch_ok) begin
      res_o.pulse_count = signed'(tot_rd);
      res_o.speed       = speed_q[addr];
      res_o.signal_ok   = flag_q[addr];
    end else begin
      res_o.pulse_count = '0;
      res_o.speed       = '0;
      res_o.signal_ok   = 1'b0;
    end
    res_o.pulse_accepted = acc_q;
  end

  // current event, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // sequencer and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      acc_q      <= 1'b0;
      tick_idx_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        total_q[i] <= '0;
        last_q[i]  <= '0;
        speed_q[i] <= '0;
        flag_q[i]  <= 1'b0;
        idle_q[i]  <= '0;
        seen_q[i]  <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cmd_pop_o) begin
        acc_q      <= 1'b0;
        tick_idx_q <= '0;
      end
      if (st_q == ST_EXEC) begin
        case (cur_q.kind)
          OP_CAPTURE: begin
            if (!noise_hit) begin
              total_q[addr] <= COUNT_W'(tot_rd + 1'b1);
              flag_q[addr]  <= 1'b1;
              last_q[addr]  <= cur_q.capture_time;
              acc_q         <= 1'b1;
            end
          end
          OP_TICK: begin
            // stall detector for one channel per cycle
            if (is_idle) begin
              if (idle_inc >= cfg_i.stall_ticks) begin
                speed_q[addr] <= '0;
                idle_q[addr]  <= '0;
              end else begin
                idle_q[addr] <= idle_inc;
              end
            end else begin
              idle_q[addr] <= '0;
              seen_q[addr] <= tot_rd;
            end
            if (!tick_last) tick_idx_q <= CHW'(tick_idx_q + 1'b1);
          end
          OP_CLEAR: begin
            total_q[addr] <= '0;
            last_q[addr]  <= '0;
            speed_q[addr] <= '0;
            flag_q[addr]  <= 1'b0;
          end
          default: ;
        endcase
      end
      // keep the quotient only below the alias limit
      if (st_q == ST_DIV && div_rsp_i.done) begin
        if (div_rsp_i.quotient < {{(SCALE_W-SPEED_W){1'b0}}, cfg_i.speed_limit}) begin
          speed_q[addr] <= div_rsp_i.quotient[SPEED_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hdl/encoder_period_speed_meter.sv =====
// Flow: a capture that passes the noise filter with a nonzero period goes through ST_EXEC,
//   ST_DIV (24 divider steps) and ST_OUT; any other event goes through ST_EXEC and ST_OUT,
//   and a tick stays in ST_EXEC while it walks every channel for the stall check.
// The back end handles one event at a time and takes no new one until the last result
//   beat is pushed; the command and result queues (FIFO_DEPTH beats each, two by default)
//   let the input and output sides stall on their own.
// Reset: rst_ni is asynchronous, active low; it clears all channel state and the queues
//   and sets the registers to their defaults.
module encoder_period_speed_meter import epsm_pkg::*; #(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDXW-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                op_i,
  input  logic                      channel_i,
  input  logic [TIME_W-1:0]         capture_time_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [COUNT_W-1:0] pulse_count_o,
  output logic [SPEED_W-1:0]        speed_o,
  output logic                      signal_ok_o,
  output logic                      pulse_accepted_o
);

  cfg_t     cfg_q;
  cmd_t     cmd;
  logic     cmd_valid, cmd_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res_in, res_out;
  logic     res_push, res_full;
  logic [$bits(res_t)-1:0] res_raw;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_period <= NOISE_RST;
      cfg_q.speed_scale  <= SCALE_RST;
      cfg_q.speed_limit  <= LIMIT_RST;
      cfg_q.stall_ticks  <= STALL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NOISE: cfg_q.noise_period <= cfg_data_i[TIME_W-1:0];
        CFG_SCALE: cfg_q.speed_scale  <= cfg_data_i[SCALE_W-1:0];
        CFG_LIMIT: cfg_q.speed_limit  <= cfg_data_i[SPEED_W-1:0];
        CFG_STALL: cfg_q.stall_ticks  <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  epsm_front #(
    .CHANNELS   (CHANNELS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .op_i           (op_i),
    .channel_i      (channel_i),
    .capture_time_i (capture_time_i),
    .cmd_pop_i      (cmd_pop),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  epsm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  epsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result queue
  epsm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign res_out          = res_t'(res_raw);
  assign pulse_count_o    = res_out.pulse_count;
  assign speed_o          = res_out.speed;
  assign signal_ok_o      = res_out.signal_ok;
  assign pulse_accepted_o = res_out.pulse_accepted;

`ifndef SYNTH
  // divider is only started while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // back end never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  // an accepted pulse always reports a live signal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pulse_accepted_o) |-> signal_ok_o)
    else $error("accepted pulse without signal_ok");

  // the back end never pops commands back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop)
    else $error("back-to-back command pop");
`endif

endmodule
